// ===== rtl/core/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
// No dependencies.
package rau_pkg;

  localparam int unsigned DW = 64;

  typedef enum logic [2:0] {
    KIND_ADD  = 3'd0,
    KIND_SUB  = 3'd1,
    KIND_MUL  = 3'd2,
    KIND_DIV  = 3'd3,
    KIND_CMP  = 3'd4,
    KIND_RECIP = 3'd5,
    KIND_INC  = 3'd6,
    KIND_DEC  = 3'd7
  } kind_e;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusDivZero = 2'd1;
  localparam logic [1:0] StatusOvf     = 2'd2;

endpackage

// ===== rtl/core/rau_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rau_pkg for the datapath width.
module rau_div import rau_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] rem_q, quo_q, dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          fits;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= fits ? diff[DW-1:0] : shifted[DW-1:0];
        quo_q <= {quo_q[DW-2:0], fits};
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/core/rational_arithmetic_unit.sv =====
// Rational ALU: add, sub, mul, div, compare, reciprocal, increment, decrement,
// arithmetic results reduced by a binary GCD. Depends on rau_pkg and rau_div.
// A zero denominator or divisor goes straight from the check to the result; add/sub takes longest,
// set by two GCD runs (one subtract-or-shift per cycle) and four divisions.
// Throughput: one request at a time; a new request is taken the cycle after the result left.
// Reset: asynchronous, active low; returns to idle with no result pending.
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] a_num_i,
  input  logic [30:0]        a_den_i,
  input  logic signed [31:0] b_num_i,
  input  logic [30:0]        b_den_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] res_num_o,
  output logic [30:0]        res_den_o,
  output logic               less_o,
  output logic               less_equal_o,
  output logic               equal_o,
  output logic [1:0]         status_o
);

  localparam logic [DW-1:0] Lim = (DW'(1) << (WIDTH - 1)) - DW'(1);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_GCD, S_DIV,
    S_AS1, S_AS2, S_AS3, S_AS4, S_AS5,
    S_MUL1, S_MUL2, S_DV1, S_DV2,
    S_CM1, S_CM2, S_CM3,
    S_RED, S_RED2, S_RED3, S_RED4, S_OUT
  } state_e;

  state_e state_q, ret_q;

  kind_e              kind_q;
  logic signed [32:0] an_q, ad_q, bn_q, bd_q;
  logic [30:0]        p_q, q_q;
  logic signed [63:0] t1_q, t2_q, num_q;
  logic [DW-1:0]      den_q, mag_q, g_q;
  logic               neg_q;
  logic [DW-1:0]      gx_q, gy_q;
  logic [5:0]         gk_q;
  logic               div_start_q;
  logic [DW-1:0]      div_n_q, div_d_q;
  logic               div_done;
  logic [DW-1:0]      div_quot;

  logic signed [31:0] res_num_q;
  logic [30:0]        res_den_q;
  logic               lt_q, le_q, eq_q;
  logic [1:0]         status_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_full;
  logic signed [63:0] prod;
  logic [DW-1:0]      num_abs;

  rau_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_q),
    .dividend_i(div_n_q),
    .divisor_i (div_d_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_comb begin
    unique case (state_q)
      S_AS3:   begin mul_a = an_q;             mul_b = {2'b00, p_q}; end
      S_AS4:   begin mul_a = bn_q;             mul_b = {2'b00, q_q}; end
      S_AS5:   begin mul_a = {2'b00, q_q};     mul_b = bd_q;         end
      S_MUL1:  begin mul_a = an_q;             mul_b = bn_q;         end
      S_MUL2:  begin mul_a = ad_q;             mul_b = bd_q;         end
      S_DV1:   begin mul_a = an_q;             mul_b = bd_q;         end
      S_DV2:   begin mul_a = ad_q;             mul_b = bn_q;         end
      S_CM1:   begin mul_a = an_q;             mul_b = bd_q;         end
      S_CM2:   begin mul_a = bn_q;             mul_b = ad_q;         end
      default: begin mul_a = '0;               mul_b = '0;           end
    endcase
  end

  assign prod_full = mul_a * mul_b;
  assign prod      = prod_full[63:0];
  assign num_abs   = num_q[63] ? DW'(-num_q) : DW'(num_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q    <= kind_e'(kind_i);
            an_q      <= {a_num_i[31], a_num_i};
            ad_q      <= {2'b00, a_den_i};
            bn_q      <= {b_num_i[31], b_num_i};
            bd_q      <= {2'b00, b_den_i};
            res_num_q <= '0;
            res_den_q <= 31'd1;
            lt_q      <= 1'b0;
            le_q      <= 1'b0;
            eq_q      <= 1'b0;
            status_q  <= StatusOk;
            state_q   <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (ad_q == '0 || (kind_q <= KIND_CMP && bd_q == '0)) begin
            status_q <= StatusDivZero;
            state_q  <= S_OUT;
          end else begin
            unique case (kind_q)
              KIND_ADD, KIND_SUB: begin
                gx_q    <= DW'(ad_q);
                gy_q    <= DW'(bd_q);
                gk_q    <= '0;
                ret_q   <= S_AS1;
                state_q <= S_GCD;
              end
              KIND_MUL: state_q <= S_MUL1;
              KIND_DIV: begin
                if (bn_q == '0) begin
                  status_q <= StatusDivZero;
                  state_q  <= S_OUT;
                end else begin
                  state_q <= S_DV1;
                end
              end
              KIND_CMP: state_q <= S_CM1;
              KIND_RECIP: begin
                if (an_q == '0) begin
                  status_q <= StatusDivZero;
                  state_q  <= S_OUT;
                end else begin
                  num_q   <= an_q[32] ? -64'(ad_q) : 64'(ad_q);
                  den_q   <= an_q[32] ? DW'(-an_q) : DW'(an_q);
                  state_q <= S_RED;
                end
              end
              KIND_INC: begin
                num_q   <= 64'(an_q) + 64'(ad_q);
                den_q   <= DW'(ad_q);
                state_q <= S_RED;
              end
              KIND_DEC: begin
                num_q   <= 64'(an_q) - 64'(ad_q);
                den_q   <= DW'(ad_q);
                state_q <= S_RED;
              end
            endcase
          end
        end
        S_GCD: begin
          priority if (gx_q == '0 || gy_q == '0) begin
            g_q     <= (gx_q | gy_q) << gk_q;
            state_q <= ret_q;
          end else if (!gx_q[0] && !gy_q[0]) begin
            gx_q <= gx_q >> 1;
            gy_q <= gy_q >> 1;
            gk_q <= gk_q + 6'd1;
          end else if (!gx_q[0]) begin
            gx_q <= gx_q >> 1;
          end else if (!gy_q[0]) begin
            gy_q <= gy_q >> 1;
          end else if (gx_q >= gy_q) begin
            gx_q <= gx_q - gy_q;
          end else begin
            gy_q <= gy_q - gx_q;
          end
        end
        S_DIV: begin
          if (div_done) state_q <= ret_q;
        end
        S_AS1: begin
          div_n_q     <= DW'(bd_q);
          div_d_q     <= g_q;
          div_start_q <= 1'b1;
          ret_q       <= S_AS2;
          state_q     <= S_DIV;
        end
        S_AS2: begin
          p_q         <= div_quot[30:0];
          div_n_q     <= DW'(ad_q);
          div_d_q     <= g_q;
          div_start_q <= 1'b1;
          ret_q       <= S_AS3;
          state_q     <= S_DIV;
        end
        S_AS3: begin
          q_q     <= div_quot[30:0];
          t1_q    <= prod;
          state_q <= S_AS4;
        end
        S_AS4: begin
          t2_q    <= prod;
          state_q <= S_AS5;
        end
        S_AS5: begin
          den_q   <= DW'(prod);
          num_q   <= (kind_q == KIND_SUB) ? t1_q - t2_q : t1_q + t2_q;
          state_q <= S_RED;
        end
        S_MUL1: begin
          num_q   <= prod;
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          den_q   <= DW'(prod);
          state_q <= S_RED;
        end
        S_DV1: begin
          t1_q    <= prod;
          state_q <= S_DV2;
        end
        S_DV2: begin
          num_q   <= prod[63] ? -t1_q : t1_q;
          den_q   <= prod[63] ? DW'(-prod) : DW'(prod);
          state_q <= S_RED;
        end
        S_CM1: begin
          t1_q    <= prod;
          state_q <= S_CM2;
        end
        S_CM2: begin
          t2_q    <= prod;
          state_q <= S_CM3;
        end
        S_CM3: begin
          lt_q    <= t1_q < t2_q;
          le_q    <= t1_q <= t2_q;
          eq_q    <= t1_q == t2_q;
          state_q <= S_OUT;
        end
        S_RED: begin
          neg_q <= num_q[63];
          mag_q <= num_abs;
          if (num_q == '0) begin
            state_q <= S_OUT;
          end else begin
            gx_q    <= num_abs;
            gy_q    <= den_q;
            gk_q    <= '0;
            ret_q   <= S_RED2;
            state_q <= S_GCD;
          end
        end
        S_RED2: begin
          div_n_q     <= mag_q;
          div_d_q     <= g_q;
          div_start_q <= 1'b1;
          ret_q       <= S_RED3;
          state_q     <= S_DIV;
        end
        S_RED3: begin
          mag_q       <= div_quot;
          div_n_q     <= den_q;
          div_d_q     <= g_q;
          div_start_q <= 1'b1;
          ret_q       <= S_RED4;
          state_q     <= S_DIV;
        end
        S_RED4: begin
          if (div_quot > Lim || mag_q > Lim + DW'(neg_q)) begin
            status_q <= StatusOvf;
          end else begin
            res_num_q <= neg_q ? -mag_q[31:0] : mag_q[31:0];
            res_den_q <= div_quot[30:0];
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign res_num_o    = res_num_q;
  assign res_den_o    = res_den_q;
  assign less_o       = lt_q;
  assign less_equal_o = le_q;
  assign equal_o      = eq_q;
  assign status_o     = status_q;

endmodule
